### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/usit_pkg.sv
// ---------------------------------------------------------------------------
// usit_pkg
// Types, codes and the unit factor table of the unit-scaled interval timer.
// ---------------------------------------------------------------------------
package usit_pkg;

  // Command codes carried in the func field
  typedef enum logic [2:0] {
    FN_QUERY   = 3'd0,
    FN_START   = 3'd1,
    FN_ALIGNED = 3'd2,
    FN_STRICT  = 3'd3,
    FN_CHANGE  = 3'd4,
    FN_FREE    = 3'd5,
    FN_OFF     = 3'd6
  } func_t;

  // Timer run state
  typedef enum logic [1:0] {
    RUN_OFF     = 2'd0,
    RUN_DOWN    = 2'd1,
    RUN_ELAPSED = 2'd2,
    RUN_FREE    = 2'd3
  } run_state_t;

  // Sequencer state
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_MUL,
    SEQ_FINISH
  } seq_state_t;

  // Time unit register codes
  localparam logic [2:0] UNIT_MS      = 3'd0;
  localparam logic [2:0] UNIT_HUNDRED = 3'd1;
  localparam logic [2:0] UNIT_TENTH   = 3'd2;
  localparam logic [2:0] UNIT_SECOND  = 3'd3;
  localparam logic [2:0] UNIT_MINUTE  = 3'd4;
  localparam logic [2:0] UNIT_HRS     = 3'd5;

  localparam int TickW = 32;
  localparam int CntW  = $clog2(TickW);

  typedef struct packed {
    logic [2:0]       func;
    logic [TickW-1:0] now_tick;
    logic [TickW-1:0] period_units;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       run_state_code;
    logic             is_on;
    logic             is_zero;
    logic             is_elapsed;
    logic [TickW-1:0] elapsed_units;
    logic [TickW-1:0] remaining_units;
    logic [TickW-1:0] overall_units;
  } out_item_t;

  // Milliseconds per unit; unused codes count in milliseconds
  function automatic logic [TickW-1:0] unit_factor(input logic [2:0] unit);
    logic [TickW-1:0] f;
    unique case (unit)
      UNIT_MS:      f = 32'd1;
      UNIT_HUNDRED: f = 32'd10;
      UNIT_TENTH:   f = 32'd100;
      UNIT_SECOND:  f = 32'd1000;
      UNIT_MINUTE:  f = 32'd60000;
      UNIT_HRS:     f = 32'd3600000;
      default:      f = 32'd1;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/unit_scaled_interval_timer_core.sv
// ---------------------------------------------------------------------------
// unit_scaled_interval_timer_core
// Interval timer on a free-running millisecond tick, with times reported in
// a configurable unit through a shared bit-serial divider.
// ---------------------------------------------------------------------------
//  channel  | signals                           | dir
//  ---------+-----------------------------------+-----
//  command  | in_valid, in_ready, in_data       | in
//  result   | out_valid, out_ready, out_data    | out
//  config   | cfg_wr_en, cfg_wr_data            | in
//
// An item with no arithmetic goes from idle straight to the finish step; a
// strict aligned start from elapsed takes one multiply, a query while
// counting down or free running a 32-step restoring divide, an aligned start
// from elapsed the divide, then the multiply. Synchronous reset clears the
// timer to off with unit milliseconds. A stalled result waits in the output
// register; the next transfer is taken, its result held in the finish step.
// ---------------------------------------------------------------------------
module unit_scaled_interval_timer_core
  import usit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

`include "assert_macros.svh"

  seq_state_t       seq, seq_next;
  run_state_t       run_state, run_state_next;
  logic [TickW-1:0] start_tick, start_tick_next;
  logic [TickW-1:0] period_len, period_len_next;
  logic [2:0]       time_unit;

  // Latched item and datapath registers
  logic [2:0]       op_func;
  logic [TickW-1:0] op_now;
  logic [TickW-1:0] op_period;
  logic [TickW-1:0] divisor;
  logic [TickW-1:0] rem;
  logic [TickW-1:0] quo;
  logic [CntW-1:0]  bit_cnt;
  logic [TickW-1:0] prod;

  logic             in_fire;
  logic             finish_fire;
  logic             div_last;
  logic [2:0]       sel_func;
  logic             need_div;
  logic             need_mul;
  logic [TickW:0]   trial;
  out_item_t        result;

  assign in_fire     = in_valid && in_ready;
  assign div_last    = (bit_cnt == CntW'(TickW - 1));
  assign sel_func    = (seq == SEQ_IDLE) ? in_data.func : op_func;

  // Decide which shared steps the item needs
  always_comb begin
    need_div = 1'b0;
    need_mul = 1'b0;
    case (func_t'(sel_func))
      FN_QUERY:   need_div = (run_state == RUN_DOWN) || (run_state == RUN_FREE);
      FN_ALIGNED: begin
        need_div = (run_state == RUN_ELAPSED);
        need_mul = (run_state == RUN_ELAPSED);
      end
      FN_STRICT:  need_mul = (run_state == RUN_ELAPSED);
      default:    ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: begin
        if (in_fire) begin
          if (need_div)      seq_next = SEQ_DIV;
          else if (need_mul) seq_next = SEQ_MUL;
          else               seq_next = SEQ_FINISH;
        end
      end
      SEQ_DIV: begin
        if (div_last) seq_next = need_mul ? SEQ_MUL : SEQ_FINISH;
      end
      SEQ_MUL:    seq_next = SEQ_FINISH;
      SEQ_FINISH: begin
        if (!out_valid || out_ready) seq_next = SEQ_IDLE;
      end
      default:    seq_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = (seq == SEQ_IDLE);
    finish_fire = (seq == SEQ_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) seq <= SEQ_IDLE;
    else     seq <= seq_next;
  end

  // Restoring division step: shift one dividend bit in, subtract if it fits
  assign trial = {rem, quo[TickW-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_func   <= in_data.func;
      op_now    <= in_data.now_tick;
      op_period <= in_data.period_units;
      divisor   <= unit_factor(time_unit);
      quo       <= in_data.now_tick - start_tick;
      rem       <= '0;
      bit_cnt   <= '0;
    end else if (seq == SEQ_DIV) begin
      bit_cnt <= bit_cnt + CntW'(1);
      if (!trial[TickW]) begin
        rem <= trial[TickW-1:0];
        quo <= {quo[TickW-2:0], 1'b1};
      end else begin
        rem <= {rem[TickW-2:0], quo[TickW-1]};
        quo <= {quo[TickW-2:0], 1'b0};
      end
    end
    // Old duration in ticks, for advancing from the end of the period
    if (seq == SEQ_MUL) begin
      prod <= TickW'(period_len * divisor);
    end
  end

  // Apply the command and form the result
  always_comb begin
    run_state_next  = run_state;
    start_tick_next = start_tick;
    period_len_next = period_len;
    result          = '0;
    case (func_t'(op_func))
      FN_QUERY: begin
        if (run_state == RUN_DOWN && quo >= period_len) run_state_next = RUN_ELAPSED;
        case (run_state_next)
          RUN_DOWN: begin
            result.elapsed_units   = quo;
            result.remaining_units = period_len - quo;
            result.overall_units   = period_len;
          end
          RUN_ELAPSED: begin
            result.is_zero       = 1'b1;
            result.is_elapsed    = 1'b1;
            result.elapsed_units = period_len;
            result.overall_units = period_len;
          end
          RUN_FREE: result.elapsed_units = quo;
          default:  result.is_zero = 1'b1;
        endcase
      end
      FN_START, FN_ALIGNED, FN_STRICT: begin
        run_state_next  = RUN_DOWN;
        period_len_next = op_period;
        start_tick_next = op_now;
        // A plain start never carries on from the end of the old period
        if (run_state == RUN_ELAPSED && func_t'(op_func) != FN_START) begin
          if (func_t'(op_func) == FN_STRICT ||
              quo < TickW'(period_len + op_period)) begin
            start_tick_next = start_tick + prod;
          end
        end
      end
      FN_CHANGE: begin
        if (run_state == RUN_DOWN || run_state == RUN_ELAPSED) begin
          run_state_next  = RUN_DOWN;
          period_len_next = op_period;
        end
      end
      FN_FREE: begin
        run_state_next  = RUN_FREE;
        period_len_next = '0;
        start_tick_next = op_now;
      end
      FN_OFF:  run_state_next = RUN_OFF;
      default: ;
    endcase
    result.run_state_code = run_state_next;
    result.is_on          = (run_state_next != RUN_OFF);
  end

  // Timer state; a unit write forces the timer off
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state  <= RUN_OFF;
      start_tick <= '0;
      period_len <= '0;
      time_unit  <= UNIT_MS;
    end else if (cfg_wr_en) begin
      run_state <= RUN_OFF;
      time_unit <= cfg_wr_data;
    end else if (finish_fire) begin
      run_state  <= run_state_next;
      start_tick <= start_tick_next;
      period_len <= period_len_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)              out_valid <= 1'b0;
    else if (finish_fire) out_valid <= 1'b1;
    else if (out_ready)   out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish_fire) out_data <= result;
  end

  `ASSERT_IMPLIES(a_on_matches_state, out_valid, out_data.is_on == (out_data.run_state_code != RUN_OFF))
  `ASSERT_IMPLIES(a_remaining_bounded, out_valid, out_data.remaining_units <= out_data.overall_units)
  `ASSERT_NEXT(a_cfg_forces_off, cfg_wr_en, run_state == RUN_OFF)

endmodule

### tb/sv/unit_scaled_interval_timer_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unit_scaled_interval_timer_core_test
// Drives command and query transfers into the interval timer with random
// bursts and gaps on the input and random stalls on the output. Every
// result is checked field by field against a local timer model of run
// state, start tick, duration and time unit, or a fixed answer in some
// directed rows. A directed script opens the run; random phases follow.
// ---------------------------------------------------------------------------
module unit_scaled_interval_timer_core_test;
  import usit_pkg::*;

  // Spare codes the block must still accept
  localparam logic [2:0] FN_SPARE     = 3'd7;
  localparam logic [2:0] UNIT_SPARE_A = 3'd6;
  localparam logic [2:0] UNIT_SPARE_B = 3'd7;

  localparam int PhaseItems = 145;
  localparam int DrainCycles = 40;
  localparam int HoldCycles = 300;
  localparam int HoldAfter = 80;

  // Answers that can be read off directly
  localparam out_item_t OFF_QUERY = '{RUN_OFF, 1'b0, 1'b1, 1'b0, '0, '0, '0};
  localparam out_item_t OFF_ACK   = '{RUN_OFF, 1'b0, 1'b0, 1'b0, '0, '0, '0};
  localparam out_item_t DOWN_ACK  = '{RUN_DOWN, 1'b1, 1'b0, 1'b0, '0, '0, '0};
  localparam out_item_t FREE_ACK  = '{RUN_FREE, 1'b1, 1'b0, 1'b0, '0, '0, '0};

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;

  // Timer model state
  run_state_t  timer_state = RUN_OFF;
  logic [31:0] tick_origin = '0;
  logic [31:0] span_units = '0;
  logic [2:0]  unit_sel = UNIT_MS;

  out_item_t   pending_answers[$];
  script_row_t directed_rows[$];
  logic [31:0] tick_clock = '0;
  int          answers_seen = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  bit          long_hold = 1'b0;

  unit_scaled_interval_timer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Milliseconds per unit; spare codes count in milliseconds
  function automatic logic [31:0] ticks_per_unit(input logic [2:0] unit);
    case (unit)
      UNIT_HUNDRED: return 32'd10;
      UNIT_TENTH:   return 32'd100;
      UNIT_SECOND:  return 32'd1000;
      UNIT_MINUTE:  return 32'd60000;
      UNIT_HRS:     return 32'd3600000;
      default:      return 32'd1;
    endcase
  endfunction

  // Apply one item to the timer model and return its answer
  function automatic out_item_t advance_timer(input in_item_t item);
    out_item_t   res;
    logic [31:0] div;
    logic [31:0] since;
    div = ticks_per_unit(unit_sel);
    since = (item.now_tick - tick_origin) / div;
    res = '0;
    case (item.func)
      FN_QUERY: begin
        if (timer_state == RUN_DOWN && since >= span_units)
          timer_state = RUN_ELAPSED;
        case (timer_state)
          RUN_DOWN: begin
            res.elapsed_units = since;
            res.remaining_units = span_units - since;
            res.overall_units = span_units;
          end
          RUN_ELAPSED: begin
            res.is_zero = 1'b1;
            res.is_elapsed = 1'b1;
            res.elapsed_units = span_units;
            res.overall_units = span_units;
          end
          RUN_FREE: res.elapsed_units = since;
          default: res.is_zero = 1'b1;
        endcase
      end
      FN_START, FN_ALIGNED, FN_STRICT: begin
        // only an elapsed timer carries on from the end of its period
        if (timer_state == RUN_ELAPSED && item.func != FN_START &&
            !(item.func == FN_ALIGNED &&
              since >= 32'(span_units + item.period_units)))
          tick_origin = tick_origin + 32'(span_units * div);
        else
          tick_origin = item.now_tick;
        timer_state = RUN_DOWN;
        span_units = item.period_units;
      end
      FN_CHANGE: begin
        if (timer_state == RUN_DOWN || timer_state == RUN_ELAPSED) begin
          timer_state = RUN_DOWN;
          span_units = item.period_units;
        end
      end
      FN_FREE: begin
        timer_state = RUN_FREE;
        span_units = '0;
        tick_origin = item.now_tick;
      end
      FN_OFF: timer_state = RUN_OFF;
      default: ;
    endcase
    res.run_state_code = timer_state;
    res.is_on = (timer_state != RUN_OFF);
    return res;
  endfunction

  // Mostly commands on a steadily advancing tick, with some noise
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0)
      tick_clock = $urandom;
    else
      tick_clock = tick_clock + $urandom_range(0, 8) * ticks_per_unit(unit_sel)
                   + $urandom_range(0, 3);
    it.now_tick = tick_clock;
    case ($urandom_range(0, 19))
      0:       it.period_units = $urandom;
      1, 2:    it.period_units = $urandom_range(0, 1000);
      default: it.period_units = $urandom_range(0, 15);
    endcase
    if (pick < 40)      it.func = FN_QUERY;
    else if (pick < 50) it.func = FN_START;
    else if (pick < 62) it.func = FN_ALIGNED;
    else if (pick < 72) it.func = FN_STRICT;
    else if (pick < 80) it.func = FN_CHANGE;
    else if (pick < 85) it.func = FN_FREE;
    else if (pick < 90) it.func = FN_OFF;
    else if (pick < 93) it.func = FN_SPARE;
    else begin
      it.func = 3'($urandom_range(0, 7));
      it.now_tick = $urandom;
      it.period_units = $urandom;
    end
    return it;
  endfunction

  task automatic add_row(input logic [2:0] func, input logic [31:0] now_tick,
                         input logic [31:0] period_units, input bit typed = 1'b0,
                         input out_item_t want = '0);
    script_row_t row;
    row.stim.func = func;
    row.stim.now_tick = now_tick;
    row.stim.period_units = period_units;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offer one transfer, opening a new burst after a random gap if due
  task automatic offer(input in_item_t item, input bit typed = 1'b0,
                       input out_item_t want = '0);
    out_item_t model_res;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (long_hold || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    model_res = advance_timer(item);
    pending_answers.push_back(typed ? want : model_res);
  endtask

  // Drain, then write the unit register; any write turns the timer off
  task automatic set_unit(input logic [2:0] unit);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= unit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unit_sel = unit;
    timer_state = RUN_OFF;
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch: got %0h, want %0h", $time, field, got, want);
  endtask

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        note_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.run_state_code !== want.run_state_code)
          note_mismatch("run_state_code", 32'(out_data.run_state_code),
                        32'(want.run_state_code));
        if (out_data.is_on !== want.is_on)
          note_mismatch("is_on", 32'(out_data.is_on), 32'(want.is_on));
        if (out_data.is_zero !== want.is_zero)
          note_mismatch("is_zero", 32'(out_data.is_zero), 32'(want.is_zero));
        if (out_data.is_elapsed !== want.is_elapsed)
          note_mismatch("is_elapsed", 32'(out_data.is_elapsed), 32'(want.is_elapsed));
        if (out_data.elapsed_units !== want.elapsed_units)
          note_mismatch("elapsed_units", out_data.elapsed_units, want.elapsed_units);
        if (out_data.remaining_units !== want.remaining_units)
          note_mismatch("remaining_units", out_data.remaining_units, want.remaining_units);
        if (out_data.overall_units !== want.overall_units)
          note_mismatch("overall_units", out_data.overall_units, want.overall_units);
      end
    end
  end

  // Result side: stretches of free flow, light and heavy stalls, one long hold
  initial begin : result_drain
    int span;
    int style;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && answers_seen >= HoldAfter) begin
        held = 1'b1;
        long_hold <= 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold <= 1'b0;
      end
      span = $urandom_range(1, 40);
      style = $urandom_range(0, 2);
      repeat (span) begin
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [2:0] unit_plan [8];
    unit_plan = '{UNIT_SECOND, UNIT_HRS, UNIT_HUNDRED, UNIT_MINUTE, UNIT_TENTH,
                  UNIT_SPARE_A, UNIT_SPARE_B, UNIT_MS};

    // Directed script at the reset unit (milliseconds)
    add_row(FN_QUERY, 32'd100, 32'd0, 1'b1, OFF_QUERY);
    add_row(FN_CHANGE, 32'd200, 32'd50, 1'b1, OFF_ACK);
    add_row(FN_SPARE, 32'd300, 32'hFFFF_FFFF, 1'b1, OFF_ACK);
    add_row(FN_START, 32'd1000, 32'd100, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'd1050, 32'd0);
    add_row(FN_QUERY, 32'd1100, 32'd0);
    // aligned start before the new period has passed: carry on from the end
    add_row(FN_ALIGNED, 32'd1150, 32'd100, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'd1199, 32'd0);
    add_row(FN_QUERY, 32'd1200, 32'd0);
    // aligned start well past both periods: restart from now
    add_row(FN_ALIGNED, 32'd1500, 32'd100, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'd1600, 32'd0);
    add_row(FN_STRICT, 32'd5000, 32'd7, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'hFFFF_FFFF, 32'd0);
    add_row(FN_CHANGE, 32'd0, 32'hFFFF_FFFF, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'd0, 32'd0);
    // free run across the tick wrap
    add_row(FN_FREE, 32'hFFFF_FFF0, 32'd0, 1'b1, FREE_ACK);
    add_row(FN_QUERY, 32'd16, 32'd0);
    add_row(FN_CHANGE, 32'd20, 32'd5, 1'b1, FREE_ACK);
    add_row(FN_ALIGNED, 32'd0, 32'd0, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'd0, 32'd0);
    add_row(FN_OFF, 32'd0, 32'd0, 1'b1, OFF_ACK);
    add_row(FN_STRICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, DOWN_ACK);
    add_row(FN_QUERY, 32'h7FFF_FFFF, 32'd0);
    add_row(FN_OFF, 32'd1, 32'd0, 1'b1, OFF_ACK);
    add_row(FN_QUERY, 32'd2, 32'd0, 1'b1, OFF_QUERY);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      offer(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

    // Random phases, one per unit setting
    foreach (unit_plan[p]) begin
      set_unit(unit_plan[p]);
      tick_clock = $urandom;
      repeat (PhaseItems) offer(random_item());
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
